// File: hw/rtl/lds_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lds_pkg
// Shared types and constants of the scheduled three-channel LED dimmer.
// ----------------------------------------------------------------------------
package lds_pkg;

  localparam int unsigned NumCh    = 3;
  localparam int unsigned DutyW    = 8;
  localparam int unsigned HourW    = 5;
  localparam int unsigned MinW     = 6;
  localparam int unsigned SecW     = 6;
  localparam int unsigned SampleW  = 12;
  localparam int unsigned ChanW    = 2;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 6;

  localparam logic [SecW-1:0]  SwitchSecond = SecW'(58);
  localparam logic [DutyW-1:0] NightOne     = DutyW'(125);
  localparam logic [DutyW-1:0] NightTwo     = DutyW'(44);
  localparam logic [DutyW-1:0] NightThree   = DutyW'(200);
  localparam int unsigned      SampleShift  = 4;

  localparam logic [CfgIdxW-1:0] RegOnHour     = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegOnMinute   = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] RegOffHour    = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] RegOffMinute  = CfgIdxW'(3);
  localparam logic [CfgIdxW-1:0] RegAutoBright = CfgIdxW'(4);
  localparam logic [CfgIdxW-1:0] RegNightLight = CfgIdxW'(5);

  localparam logic KindTick  = 1'b0;
  localparam logic KindWrite = 1'b1;

  typedef logic [NumCh-1:0][DutyW-1:0] duty_vec_t;

  typedef struct packed {
    logic [HourW-1:0] on_hour;
    logic [MinW-1:0]  on_minute;
    logic [HourW-1:0] off_hour;
    logic [MinW-1:0]  off_minute;
    logic             auto_brightness;
    logic             night_light;
  } cfg_t;

  typedef struct packed {
    logic               kind;
    logic [SampleW-1:0] light_sample;
    logic [HourW-1:0]   clock_hour;
    logic [MinW-1:0]    clock_minute;
    logic [SecW-1:0]    clock_second;
    logic [ChanW-1:0]   target_channel;
    logic [DutyW-1:0]   target_value;
  } item_t;

  typedef struct packed {
    duty_vec_t duty;
    logic      lamp_on;
    logic      settled;
  } result_t;

endpackage
`default_nettype wire

// File: hw/rtl/lds_cfg_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lds_cfg_regs
// Schedule and mode register file written through the configuration channel.
// ----------------------------------------------------------------------------
module lds_cfg_regs import lds_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                wr_en_i,
  input  wire logic [CfgIdxW-1:0]  wr_index_i,
  input  wire logic [CfgDataW-1:0] wr_data_i,
  output cfg_t                     cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (wr_index_i)
        RegOnHour:     cfg_d.on_hour         = wr_data_i[HourW-1:0];
        RegOnMinute:   cfg_d.on_minute       = wr_data_i[MinW-1:0];
        RegOffHour:    cfg_d.off_hour        = wr_data_i[HourW-1:0];
        RegOffMinute:  cfg_d.off_minute      = wr_data_i[MinW-1:0];
        RegAutoBright: cfg_d.auto_brightness = wr_data_i[0];
        RegNightLight: cfg_d.night_light     = wr_data_i[0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

// File: hw/rtl/lds_update.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lds_update
// Duty, target and power state with the per-beat schedule and slew update.
// ----------------------------------------------------------------------------
module lds_update import lds_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire item_t item_i,
  input  wire cfg_t  cfg_i,
  input  wire logic  commit_i,
  output result_t    res_o
);

  duty_vec_t duty_q, duty_d;
  duty_vec_t tgt_q, tgt_d;
  logic      pwr_q, pwr_d;
  logic      on_hit, off_hit, moved;
  logic [DutyW-1:0] level;

  assign level   = item_i.light_sample[SampleW-1 -: DutyW];
  assign on_hit  = (cfg_i.on_hour == item_i.clock_hour) &&
                   (cfg_i.on_minute == item_i.clock_minute) &&
                   (item_i.clock_second == SwitchSecond);
  assign off_hit = (cfg_i.off_hour == item_i.clock_hour) &&
                   (cfg_i.off_minute == item_i.clock_minute) &&
                   (item_i.clock_second == SwitchSecond);

  always_comb begin
    duty_d = duty_q;
    tgt_d  = tgt_q;
    pwr_d  = pwr_q;
    moved  = 1'b0;
    if (item_i.kind == KindTick) begin
      if (on_hit) pwr_d = 1'b1;
      if (off_hit) pwr_d = 1'b0;
      if (!pwr_d) tgt_d = '0;
      if (cfg_i.auto_brightness) begin
        for (int c = 0; c < NumCh; c++) begin
          tgt_d[c]  = level;
          duty_d[c] = level;
        end
      end
      if (cfg_i.night_light) begin
        tgt_d[0] = NightOne;
        tgt_d[1] = NightTwo;
        tgt_d[2] = NightThree;
      end
      for (int c = 0; c < NumCh; c++) begin
        if (!moved && (duty_d[c] > tgt_d[c])) begin
          duty_d[c] = duty_d[c] - DutyW'(1);
          moved     = 1'b1;
        end else if (!moved && (duty_d[c] < tgt_d[c])) begin
          duty_d[c] = duty_d[c] + DutyW'(1);
          moved     = 1'b1;
        end
      end
    end else begin
      for (int c = 0; c < NumCh; c++) begin
        if (item_i.target_channel == ChanW'(c)) tgt_d[c] = item_i.target_value;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duty_q <= '0;
      tgt_q  <= '0;
      pwr_q  <= 1'b0;
    end else if (commit_i) begin
      duty_q <= duty_d;
      tgt_q  <= tgt_d;
      pwr_q  <= pwr_d;
    end
  end

  assign res_o.duty    = duty_d;
  assign res_o.lamp_on = pwr_d;
  assign res_o.settled = (duty_d == tgt_d);

endmodule
`default_nettype wire

// File: hw/rtl/led_dimmer_slew_scheduler.sv
`default_nettype none
// ----------------------------------------------------------------------------
// led_dimmer_slew_scheduler
// Three-channel LED dimmer with a daily on/off schedule and duty slewing.
// Each beat passes an input register and then a result register; throughput:
// one beat per cycle unless the output stalls, set by the single-pass update.
// Reset: duties, targets, power state (lamp off) and valid flags cleared;
// the block accepts beats right after reset.
// ----------------------------------------------------------------------------
module led_dimmer_slew_scheduler import lds_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_valid_i,
  output wire logic                cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire logic                in_valid_i,
  output wire logic                in_ready_o,
  input  wire logic                kind_i,
  input  wire logic [SampleW-1:0]  light_sample_i,
  input  wire logic [HourW-1:0]    clock_hour_i,
  input  wire logic [MinW-1:0]     clock_minute_i,
  input  wire logic [SecW-1:0]     clock_second_i,
  input  wire logic [ChanW-1:0]    target_channel_i,
  input  wire logic [DutyW-1:0]    target_value_i,
  output wire logic                out_valid_o,
  input  wire logic                out_ready_i,
  output wire logic [DutyW-1:0]    duty_one_o,
  output wire logic [DutyW-1:0]    duty_two_o,
  output wire logic [DutyW-1:0]    duty_three_o,
  output wire logic                lamp_on_o,
  output wire logic                settled_o
);

  cfg_t    cfg;
  item_t   item_q;
  result_t res_d, res_q;
  logic    in_vld_q, out_vld_q;
  logic    out_free, advance, in_take;

  assign cfg_ready_o = 1'b1;

  lds_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  assign out_free   = !out_vld_q || out_ready_i;
  assign advance    = in_vld_q && out_free;
  assign in_ready_o = !in_vld_q || advance;
  assign in_take    = in_valid_i && in_ready_o;

  // input beat register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.kind           <= kind_i;
      item_q.light_sample   <= light_sample_i;
      item_q.clock_hour     <= clock_hour_i;
      item_q.clock_minute   <= clock_minute_i;
      item_q.clock_second   <= clock_second_i;
      item_q.target_channel <= target_channel_i;
      item_q.target_value   <= target_value_i;
    end
  end

  lds_update u_update (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_q),
    .cfg_i    (cfg),
    .commit_i (advance),
    .res_o    (res_d)
  );

  // result beat register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign duty_one_o   = res_q.duty[0];
  assign duty_two_o   = res_q.duty[1];
  assign duty_three_o = res_q.duty[2];
  assign lamp_on_o    = res_q.lamp_on;
  assign settled_o    = res_q.settled;

endmodule
`default_nettype wire
